FILE: hdl/bearing_to_point_core_macros.svh
// Assertion macros for the bearing_to_point core.
`ifndef BEARING_TO_POINT_CORE_MACROS_SVH
`define BEARING_TO_POINT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bearing_to_point_core: assertion failed");

// Next-cycle implication.
`define BTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bearing_to_point_core: assertion failed");

`else

`define BTP_ASSERT_NOW(lbl, ante, cons)
`define BTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/btp_pkg.sv
package btp_pkg;

	localparam int COORD_W   = 16;
	localparam int DIFF_W    = 17;
	localparam int HEAD_W    = 16;
	localparam int BEAR_W    = 15;
	localparam int TURN_W    = 17;
	localparam int PRESCALE_SH = 12;
	localparam int CRD_W     = 32;
	localparam int ACC_W     = 32;
	localparam int ROUND_SH  = 9;
	localparam int TABLE_LEN = 24;

	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [TURN_W-1:0] FULL_TURN_OUT = 17'd46080;
	localparam logic signed [ACC_W-1:0] FULL_TURN_ACC = 32'sd23592960;
	localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = 32'sd11796480;
	localparam logic signed [ACC_W-1:0] ROUND_HALF    = 32'sd256;

	// atan(2^-i) in degrees * 2^16
	localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
		32'sd234379,  32'sd117306,  32'sd58666,  32'sd29335,
		32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
		32'sd917,     32'sd458,     32'sd229,    32'sd115,
		32'sd57,      32'sd29,      32'sd14,     32'sd7,
		32'sd4,       32'sd2,       32'sd1,      32'sd0
	};

	// Side data that rides along with each word through the rotation chain.
	typedef struct packed {
		logic              vld;
		logic              zero;
		logic [HEAD_W-1:0] cur;
	} btp_side_t;

endpackage

FILE: hdl/btp_prep.sv
module btp_prep (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_x,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_y,
	input  logic signed [btp_pkg::COORD_W-1:0] target_x,
	input  logic signed [btp_pkg::COORD_W-1:0] target_y,
	input  logic        [btp_pkg::HEAD_W-1:0]  current_heading,
	output logic signed [btp_pkg::CRD_W-1:0]   x_s1,
	output logic signed [btp_pkg::CRD_W-1:0]   y_s1,
	output logic signed [btp_pkg::ACC_W-1:0]   z_s1,
	output btp_pkg::btp_side_t                 side_s1
);

	localparam int EXT_W = btp_pkg::CRD_W - btp_pkg::DIFF_W - btp_pkg::PRESCALE_SH;

	logic signed [btp_pkg::DIFF_W-1:0] dx;
	logic signed [btp_pkg::DIFF_W-1:0] dy;
	logic signed [btp_pkg::CRD_W-1:0]  x_raw;
	logic signed [btp_pkg::CRD_W-1:0]  y_raw;
	logic                              left_half;
	logic [btp_pkg::HEAD_W-1:0]        cur_w;

	assign dx = {target_x[btp_pkg::COORD_W-1], target_x}
		- {origin_x[btp_pkg::COORD_W-1], origin_x};
	assign dy = {target_y[btp_pkg::COORD_W-1], target_y}
		- {origin_y[btp_pkg::COORD_W-1], origin_y};

	assign x_raw = {{EXT_W{dx[btp_pkg::DIFF_W-1]}}, dx, {btp_pkg::PRESCALE_SH{1'b0}}};
	assign y_raw = {{EXT_W{dy[btp_pkg::DIFF_W-1]}}, dy, {btp_pkg::PRESCALE_SH{1'b0}}};
	assign left_half = dx[btp_pkg::DIFF_W-1];

	// fold an out-of-range heading back by one full turn
	always_comb begin
		if ({1'b0, current_heading} >= btp_pkg::FULL_TURN_OUT) begin
			cur_w = btp_pkg::HEAD_W'({1'b0, current_heading} - btp_pkg::FULL_TURN_OUT);
		end else begin
			cur_w = current_heading;
		end
	end

	always_ff @(posedge clk) begin
		if (left_half) begin
			x_s1 <= -x_raw;
			y_s1 <= -y_raw;
			z_s1 <= btp_pkg::HALF_TURN_ACC;
		end else begin
			x_s1 <= x_raw;
			y_s1 <= y_raw;
			z_s1 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.vld  <= accept;
			side_s1.zero <= (dx == '0) && (dy == '0);
			side_s1.cur  <= cur_w;
		end
	end

endmodule

FILE: hdl/btp_cell.sv
module btp_cell #(
	parameter int STAGE = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [btp_pkg::CRD_W-1:0] x_in,
	input  logic signed [btp_pkg::CRD_W-1:0] y_in,
	input  logic signed [btp_pkg::ACC_W-1:0] z_in,
	input  btp_pkg::btp_side_t               side_in,
	output logic signed [btp_pkg::CRD_W-1:0] x_s1,
	output logic signed [btp_pkg::CRD_W-1:0] y_s1,
	output logic signed [btp_pkg::ACC_W-1:0] z_s1,
	output btp_pkg::btp_side_t               side_s1
);

	logic signed [btp_pkg::CRD_W-1:0] xs;
	logic signed [btp_pkg::CRD_W-1:0] ys;
	logic                             rot_cw;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;
	// y strictly positive: rotate clockwise toward the x axis
	assign rot_cw = !y_in[btp_pkg::CRD_W-1] && (y_in != '0);

	always_ff @(posedge clk) begin
		if (rot_cw) begin
			x_s1 <= x_in + ys;
			y_s1 <= y_in - xs;
			z_s1 <= z_in + btp_pkg::ATAN_TAB[STAGE];
		end else begin
			x_s1 <= x_in - ys;
			y_s1 <= y_in + xs;
			z_s1 <= z_in - btp_pkg::ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_in;
		end
	end

endmodule

FILE: hdl/btp_post.sv
module btp_post (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [btp_pkg::ACC_W-1:0] z_in,
	input  btp_pkg::btp_side_t               side_in,
	output logic                             done,
	output logic [btp_pkg::BEAR_W-1:0]       bearing,
	output logic [btp_pkg::HEAD_W-1:0]       target_heading
);

	logic signed [btp_pkg::ACC_W-1:0] z_wrap;
	logic signed [btp_pkg::ACC_W-1:0] z_rnd;
	logic [btp_pkg::TURN_W-1:0]       h_rnd;
	logic [btp_pkg::HEAD_W-1:0]       h_d;

	logic                       vld_s1;
	logic [btp_pkg::HEAD_W-1:0] tgt_s1;
	logic [btp_pkg::HEAD_W-1:0] cur_s1;

	logic [btp_pkg::TURN_W-1:0] tgt_e;
	logic [btp_pkg::TURN_W-1:0] cur_e;
	logic [btp_pkg::TURN_W-1:0] left;
	logic [btp_pkg::TURN_W-1:0] right;
	logic [btp_pkg::TURN_W-1:0] best;

	// accumulator stays within one turn either side, so one correction suffices
	assign z_wrap = z_in[btp_pkg::ACC_W-1] ? z_in + btp_pkg::FULL_TURN_ACC : z_in;
	assign z_rnd  = z_wrap + btp_pkg::ROUND_HALF;
	assign h_rnd  = z_rnd[btp_pkg::ROUND_SH +: btp_pkg::TURN_W];

	always_comb begin
		if (side_in.zero || (h_rnd >= btp_pkg::FULL_TURN_OUT)) begin
			h_d = '0;
		end else begin
			h_d = h_rnd[btp_pkg::HEAD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		tgt_s1 <= h_d;
		cur_s1 <= side_in.cur;
	end

	assign tgt_e = {1'b0, tgt_s1};
	assign cur_e = {1'b0, cur_s1};
	assign left  = (tgt_e >= cur_e) ? tgt_e - cur_e : tgt_e + btp_pkg::FULL_TURN_OUT - cur_e;
	assign right = (cur_e >= tgt_e) ? cur_e - tgt_e : cur_e + btp_pkg::FULL_TURN_OUT - tgt_e;
	assign best  = (left < right) ? left : right;

	always_ff @(posedge clk) begin
		bearing        <= best[btp_pkg::BEAR_W-1:0];
		target_heading <= tgt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= side_in.vld;
			done   <= vld_s1;
		end
	end

endmodule

FILE: hdl/bearing_to_point_core.sv
// Relative bearing core: takes an origin point, a target point and the current
// heading (degrees*128), and returns the absolute heading to the target and the
// smaller turn angle to it. A word is taken on every clock where start is high;
// busy never rises, so a new word may follow every cycle. Each result appears
// CORDIC_STAGES+3 cycles after its start, marked by a one-cycle done strobe,
// and must be captured then since the core has no output stall. The latency is
// the input register, one CORDIC rotation cell per stage, and two output
// stages for heading rounding and turn selection.
`include "bearing_to_point_core_macros.svh"

module bearing_to_point_core #(
	parameter int CORDIC_STAGES = btp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_x,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_y,
	input  logic signed [btp_pkg::COORD_W-1:0] target_x,
	input  logic signed [btp_pkg::COORD_W-1:0] target_y,
	input  logic        [btp_pkg::HEAD_W-1:0]  current_heading,
	output logic                               done,
	output logic        [btp_pkg::BEAR_W-1:0]  bearing,
	output logic        [btp_pkg::HEAD_W-1:0]  target_heading
);

	localparam int LATENCY = CORDIC_STAGES + 3;

	logic signed [btp_pkg::CRD_W-1:0] x_c [CORDIC_STAGES+1];
	logic signed [btp_pkg::CRD_W-1:0] y_c [CORDIC_STAGES+1];
	logic signed [btp_pkg::ACC_W-1:0] z_c [CORDIC_STAGES+1];
	btp_pkg::btp_side_t               side_c [CORDIC_STAGES+1];

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	btp_prep u_prep (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.target_x        (target_x),
		.target_y        (target_y),
		.current_heading (current_heading),
		.x_s1            (x_c[0]),
		.y_s1            (y_c[0]),
		.z_s1            (z_c[0]),
		.side_s1         (side_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		btp_cell #(
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.side_in (side_c[i]),
			.x_s1    (x_c[i+1]),
			.y_s1    (y_c[i+1]),
			.z_s1    (z_c[i+1]),
			.side_s1 (side_c[i+1])
		);
	end

	// final x/y are not needed: only the angle accumulator and the side data leave the chain
	btp_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.z_in           (z_c[CORDIC_STAGES]),
		.side_in        (side_c[CORDIC_STAGES]),
		.done           (done),
		.bearing        (bearing),
		.target_heading (target_heading)
	);

	`BTP_ASSERT_NOW(a_bearing_range, done, bearing <= 15'd23040)
	`BTP_ASSERT_NOW(a_heading_range, done, target_heading < 16'd46080)
	`BTP_ASSERT_NOW(a_latency_fwd, accept, ##LATENCY done)
	`BTP_ASSERT_NOW(a_latency_bwd, done, $past(accept, LATENCY))

endmodule

FILE: tb/btp_checker.sv
module btp_checker #(
	parameter int CORDIC_STAGES = btp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_x,
	input  logic signed [btp_pkg::COORD_W-1:0] origin_y,
	input  logic signed [btp_pkg::COORD_W-1:0] target_x,
	input  logic signed [btp_pkg::COORD_W-1:0] target_y,
	input  logic        [btp_pkg::HEAD_W-1:0]  current_heading,
	input  logic                               done,
	input  logic        [btp_pkg::BEAR_W-1:0]  bearing,
	input  logic        [btp_pkg::HEAD_W-1:0]  target_heading,
	output int                                 mismatches,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import btp_pkg::*;

	localparam int OUT_TURN  = 46080;
	localparam int ACC_TURN  = 23592960;
	localparam int ACC_HALF  = 11796480;
	localparam int ATAN_LEN  = 24;

	typedef struct packed {
		logic [BEAR_W-1:0] bearing;
		logic [HEAD_W-1:0] heading;
	} bearing_word_t;

	// atan(2^-i), degrees * 2^16
	const int atan_deg16 [ATAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	bearing_word_t bearing_q [$];

	// CORDIC vectoring; result in degrees*128, wrapped to [0, 360)
	function automatic int heading_to(int dx, int dy);
		int x;
		int y;
		int z;
		int xs;
		int ys;
		int h;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 4096;
		y = dy * 4096;
		z = 0;
		// left half plane: rotate by 180 first
		if (x < 0) begin
			x = -x;
			y = -y;
			z = ACC_HALF;
		end
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_deg16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_deg16[i];
			end
		end
		while (z < 0)
			z += ACC_TURN;
		while (z >= ACC_TURN)
			z -= ACC_TURN;
		h = (z + 256) >>> 9;
		if (h >= OUT_TURN)
			h -= OUT_TURN;
		return h;
	endfunction

	function automatic bearing_word_t predict_bearing(
		logic signed [COORD_W-1:0] ox, logic signed [COORD_W-1:0] oy,
		logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty,
		logic [HEAD_W-1:0] hd);
		bearing_word_t w;
		int cur;
		int tgt;
		int ccw;
		int cw;
		cur = int'(hd);
		if (cur >= OUT_TURN)
			cur -= OUT_TURN;
		tgt = heading_to(int'(tx) - int'(ox), int'(ty) - int'(oy));
		ccw = (tgt >= cur) ? tgt - cur : tgt + OUT_TURN - cur;
		cw = (cur >= tgt) ? cur - tgt : cur + OUT_TURN - tgt;
		w.bearing = (ccw < cw) ? ccw[BEAR_W-1:0] : cw[BEAR_W-1:0];
		w.heading = tgt[HEAD_W-1:0];
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		bearing_word_t want;
		if (arst_n) begin
			if (start && !busy)
				bearing_q.push_back(predict_bearing(origin_x, origin_y, target_x,
					target_y, current_heading));
			if (done) begin
				if (bearing_q.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					want = bearing_q.pop_front();
					if (bearing !== want.bearing)
						report_mismatch($sformatf("bearing got %0d want %0d",
							bearing, want.bearing));
					if (target_heading !== want.heading)
						report_mismatch($sformatf("target_heading got %0d want %0d",
							target_heading, want.heading));
				end
			end
			pending = bearing_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import btp_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int RANDOM_WORDS = 1000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;
	logic [HEAD_W-1:0] current_heading;
	logic done;
	logic [BEAR_W-1:0] bearing;
	logic [HEAD_W-1:0] target_heading;
	int mismatches;
	int pending;
	int idle_pct;

	bearing_to_point_core #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.current_heading(current_heading),
		.done(done),
		.bearing(bearing),
		.target_heading(target_heading)
	);

	btp_checker #(.CORDIC_STAGES(STAGES)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.current_heading(current_heading),
		.done(done),
		.bearing(bearing),
		.target_heading(target_heading),
		.mismatches(mismatches),
		.pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

	// holds start high until the word is taken; start is left high on return, and idle cycles before the next word drop it
	task automatic send_word(int ox, int oy, int tx, int ty, int hd);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		origin_x <= ox[COORD_W-1:0];
		origin_y <= oy[COORD_W-1:0];
		target_x <= tx[COORD_W-1:0];
		target_y <= ty[COORD_W-1:0];
		current_heading <= hd[HEAD_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic int pick_coord();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic send_random_word();
		int ox;
		int oy;
		int tx;
		int ty;
		int hd;
		ox = $urandom_range(65535);
		oy = $urandom_range(65535);
		tx = $urandom_range(65535);
		ty = $urandom_range(65535);
		case ($urandom_range(9))
			0: begin
				tx = ox;
				ty = oy;
			end
			1: begin
				tx = ox + $urandom_range(8) - 4;
				ty = oy + $urandom_range(8) - 4;
			end
			2: begin
				if ($urandom_range(1))
					tx = ox;
				else
					ty = oy;
			end
			3: begin
				ox = pick_coord();
				oy = pick_coord();
				tx = pick_coord();
				ty = pick_coord();
			end
			default: ;
		endcase
		case ($urandom_range(19))
			0, 1: hd = $urandom_range(65535, 46080);
			2: hd = ($urandom_range(1)) ? 0 : 46079;
			default: hd = $urandom_range(46079);
		endcase
		send_word(ox, oy, tx, ty, hd);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		origin_x = '0;
		origin_y = '0;
		target_x = '0;
		target_y = '0;
		current_heading = '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector against headings: equal, half-turn tie, range ends, wrap
		send_word(5, -7, 5, -7, 0);
		send_word(0, 0, 0, 0, 23040);
		send_word(-32768, 32767, -32768, 32767, 46079);
		send_word(100, 100, 100, 100, 46080);
		send_word(0, 0, 0, 0, 65535);
		// widest deltas along diagonals and axes
		send_word(-32768, -32768, 32767, 32767, 0);
		send_word(32767, 32767, -32768, -32768, 11520);
		send_word(-32768, 0, 32767, 0, 46079);
		send_word(32767, 0, -32768, 0, 0);
		send_word(0, -32768, 0, 32767, 34560);
		send_word(0, 32767, 0, -32768, 11520);
		// unit steps in quadrants two to four and along three half-axes, left half plane included
		send_word(0, 0, -1, 1, 17280);
		send_word(0, 0, -1, -1, 28800);
		send_word(0, 0, 1, -1, 65535);
		send_word(0, 0, 1, 0, 46080);
		send_word(0, 0, 0, 1, 11520);
		send_word(0, 0, 0, -1, 0);
		// close to the 180 degree line from either side, then other mixed directions
		send_word(32767, 0, -32768, 1, 23040);
		send_word(32767, 0, -32768, -1, 0);
		send_word(0, 32767, 1, -32768, 40000);
		send_word(-32768, 32767, 32767, -32768, 32768);
		send_word(12345, -23456, -3210, 30000, 1);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i < RANDOM_WORDS / 3)
				idle_pct = 16;
			else if (i < 2 * RANDOM_WORDS / 3)
				idle_pct = 74;
			else
				idle_pct = 0;
			send_random_word();
		end
		start <= 1'b0;

		for (int n = 0; n < 1000 && pending != 0; n++)
			@(posedge clk);
		repeat (STAGES + 8) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/btp_pkg.sv
hdl/btp_prep.sv
hdl/btp_cell.sv
hdl/btp_post.sv
hdl/bearing_to_point_core.sv
tb/btp_checker.sv
tb/tb_top.sv
